>>> rtl/scd_pkg.sv
package scd_pkg;

  localparam int unsigned PktBytes = 64;
  localparam int unsigned PosW     = $clog2(PktBytes + 1);
  localparam int unsigned IdxW     = 9;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned QDepth   = 4;
  localparam int unsigned QPtrW    = $clog2(QDepth);
  localparam int unsigned QCntW    = $clog2(QDepth + 1);

  localparam logic [CfgIdxW-1:0] CFG_SYNC_FIRST  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SYNC_SECOND = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_CMD_LIMIT   = 2'd2;

  localparam logic [7:0] SYNC_FIRST_RST  = 8'hA5;
  localparam logic [7:0] SYNC_SECOND_RST = 8'h5A;
  localparam logic [7:0] CMD_LIMIT_RST   = 8'h0F;

  localparam logic [3:0] FT_SINGLE = 4'd0;
  localparam logic [3:0] FT_FIRST  = 4'd1;
  localparam logic [3:0] FT_CONSEC = 4'd2;

  localparam logic [IdxW-1:0] IDX_MAX = '1;

  typedef enum logic [2:0] {
    ST_SINGLE   = 3'd0,
    ST_FIRST    = 3'd1,
    ST_CONSEC   = 3'd2,
    ST_SEQ_MISS = 3'd3,
    ST_UNKNOWN  = 3'd4,
    ST_BAD_SYNC = 3'd5
  } status_e;

  typedef struct packed {
    logic [7:0] sync_first;
    logic [7:0] sync_second;
    logic [7:0] command_limit;
  } cfg_t;

  typedef struct packed {
    logic            kind;
    logic [IdxW-1:0] byte_index;
    logic [7:0]      byte_value;
    logic [2:0]      status;
    logic            message_done;
    logic [7:0]      command;
    logic            command_ok;
    logic [IdxW-1:0] message_length;
    logic            last;
  } res_t;

endpackage

>>> rtl/scd_in_if.sv
interface scd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       packet_last;

  modport source (output valid, output data_byte, output packet_last, input ready);
  modport sink (input valid, input data_byte, input packet_last, output ready);
endinterface

>>> rtl/scd_out_if.sv
interface scd_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [8:0] byte_index;
  logic [7:0] byte_value;
  logic [2:0] status;
  logic       message_done;
  logic [7:0] command;
  logic       command_ok;
  logic [8:0] message_length;
  logic       last;

  modport source (
    output valid, output kind, output byte_index, output byte_value, output status,
    output message_done, output command, output command_ok, output message_length,
    output last, input ready
  );
  modport sink (
    input valid, input kind, input byte_index, input byte_value, input status,
    input message_done, input command, input command_ok, input message_length,
    input last, output ready
  );
endinterface

>>> rtl/scd_core.sv
module scd_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          fire_i,
  input  logic [7:0]    data_byte_i,
  input  logic          packet_last_i,
  input  scd_pkg::cfg_t cfg_i,
  output scd_pkg::res_t res0_o,
  output scd_pkg::res_t res1_o,
  output logic [1:0]    push_cnt_o
);
  import scd_pkg::*;

  logic [PosW-1:0] pos_q, pos_d;
  logic [3:0]      ftype_q, ftype_d;
  logic [3:0]      nib_q, nib_d;
  logic            sync_q, sync_d;
  logic [3:0]      seq_q, seq_d;
  logic [IdxW-1:0] dlen_q, dlen_d;
  logic [IdxW-1:0] widx_q, widx_d;
  logic [7:0]      fmb_q, fmb_d;
  logic            adv_q, adv_d;
  logic            hit_q, hit_d;

  logic            store;
  logic [IdxW-1:0] len_sum;
  status_e         st;
  res_t            pay, rep;

  assign len_sum = IdxW'({nib_q, 4'd0}) + IdxW'(data_byte_i);

  always_comb begin
    pos_d   = pos_q;
    ftype_d = ftype_q;
    nib_d   = nib_q;
    sync_d  = sync_q;
    seq_d   = seq_q;
    dlen_d  = dlen_q;
    widx_d  = widx_q;
    fmb_d   = fmb_q;
    adv_d   = adv_q;
    hit_d   = hit_q;
    store   = 1'b0;
    st      = ST_BAD_SYNC;

    if (pos_q == PosW'(0)) begin
      sync_d = (data_byte_i == cfg_i.sync_first);
    end else if (pos_q == PosW'(1)) begin
      sync_d = sync_q && (data_byte_i == cfg_i.sync_second);
    end else if (pos_q == PosW'(2)) begin
      ftype_d = data_byte_i[7:4];
      nib_d   = data_byte_i[3:0];
    end else if (pos_q < PosW'(PktBytes) && sync_q) begin
      if (pos_q == PosW'(3)) begin
        if (ftype_q == FT_SINGLE || ftype_q == FT_FIRST) begin
          dlen_d = len_sum;
          widx_d = '0;
          adv_d  = 1'b1;
          if (ftype_q == FT_FIRST) begin
            seq_d = 4'd1;
          end
        end else if (ftype_q == FT_CONSEC) begin
          if (nib_q == seq_q) begin
            hit_d = 1'b1;
            seq_d = seq_q + 4'd1;
            store = widx_q < dlen_q;
          end
        end
      end else begin
        if (ftype_q == FT_SINGLE) begin
          store = widx_q < dlen_q;
        end else if (ftype_q == FT_FIRST) begin
          store = widx_q < IDX_MAX;
        end else if (ftype_q == FT_CONSEC) begin
          store = hit_q && (widx_q < dlen_q);
        end
      end
      if (store) begin
        if (widx_q == '0) begin
          fmb_d = data_byte_i;
        end
        widx_d = widx_q + IdxW'(1);
        adv_d  = 1'b1;
      end
    end

    if (pos_q < PosW'(PktBytes)) begin
      pos_d = pos_q + PosW'(1);
    end

    if (pos_q < PosW'(3) || !sync_d) begin
      st = ST_BAD_SYNC;
    end else if (ftype_d == FT_SINGLE) begin
      st = ST_SINGLE;
    end else if (ftype_d == FT_FIRST) begin
      st = ST_FIRST;
    end else if (ftype_d == FT_CONSEC) begin
      st = hit_d ? ST_CONSEC : ST_SEQ_MISS;
    end else begin
      st = ST_UNKNOWN;
    end

    rep                = '0;
    rep.kind           = 1'b1;
    rep.status         = st;
    rep.message_done   = (st == ST_SINGLE || st == ST_FIRST || st == ST_CONSEC)
                         && adv_d && (widx_d == dlen_d);
    rep.command        = fmb_d;
    rep.command_ok     = fmb_d < cfg_i.command_limit;
    rep.message_length = dlen_d;
    rep.last           = 1'b1;

    pay            = '0;
    pay.byte_index = widx_q;
    pay.byte_value = data_byte_i;
    pay.last       = !packet_last_i;

    if (packet_last_i) begin
      pos_d  = '0;
      sync_d = 1'b0;
      adv_d  = 1'b0;
      hit_d  = 1'b0;
    end
  end

  assign res0_o     = store ? pay : rep;
  assign res1_o     = rep;
  assign push_cnt_o = fire_i ? ({1'b0, store} + {1'b0, packet_last_i}) : 2'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      ftype_q <= '0;
      nib_q   <= '0;
      sync_q  <= 1'b0;
      seq_q   <= '0;
      dlen_q  <= '0;
      widx_q  <= '0;
      fmb_q   <= '0;
      adv_q   <= 1'b0;
      hit_q   <= 1'b0;
    end else if (fire_i) begin
      pos_q   <= pos_d;
      ftype_q <= ftype_d;
      nib_q   <= nib_d;
      sync_q  <= sync_d;
      seq_q   <= seq_d;
      dlen_q  <= dlen_d;
      widx_q  <= widx_d;
      fmb_q   <= fmb_d;
      adv_q   <= adv_d;
      hit_q   <= hit_d;
    end
  end

endmodule

>>> rtl/scd_outq.sv
module scd_outq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [1:0]    push_cnt_i,
  input  scd_pkg::res_t res0_i,
  input  scd_pkg::res_t res1_i,
  output logic          space_o,
  output logic          valid_o,
  input  logic          ready_i,
  output scd_pkg::res_t head_o
);
  import scd_pkg::*;

  res_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, wr_d;
  logic [QPtrW-1:0] rd_q, rd_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             pop;
  logic [QPtrW-1:0] wr_nxt;

  assign valid_o = cnt_q != '0;
  assign pop     = valid_o && ready_i;
  assign space_o = cnt_q <= QCntW'(QDepth - 2);
  assign head_o  = mem_q[rd_q];
  assign wr_nxt  = wr_q + QPtrW'(1);

  always_comb begin
    wr_d  = wr_q + QPtrW'(push_cnt_i);
    rd_d  = pop ? rd_q + QPtrW'(1) : rd_q;
    cnt_d = cnt_q + QCntW'(push_cnt_i) - QCntW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      mem_q[wr_q] <= res0_i;
    end
    if (push_cnt_i == 2'd2) begin
      mem_q[wr_nxt] <= res1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

>>> rtl/segmented_command_deframer_unit.sv
// A result beat is written into the result queue and offered once it reaches the queue head.
// Throughput: one input beat per cycle while results drain; a packet-end beat that
// also stores a payload byte yields two result beats, taken on the output in turn.
// A four-entry result queue separates the sides; input ready holds while two slots are free.
// Reset (rst_ni, async, active low): packet and message state cleared, queue emptied,
// sync_first 0xA5, sync_second 0x5A, command_limit 15.
module segmented_command_deframer_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  scd_in_if.sink                       in_i,
  scd_out_if.source                    out_o,
  input  logic                         cfg_we_i,
  input  logic [scd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [7:0]                   cfg_data_i
);
  import scd_pkg::*;

  cfg_t       cfg_q;
  res_t       res0, res1, head;
  logic [1:0] push_cnt;
  logic       space;
  logic       fire;

  assign in_i.ready = space;
  assign fire       = in_i.valid && space;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_first    <= SYNC_FIRST_RST;
      cfg_q.sync_second   <= SYNC_SECOND_RST;
      cfg_q.command_limit <= CMD_LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SYNC_FIRST:  cfg_q.sync_first    <= cfg_data_i;
        CFG_SYNC_SECOND: cfg_q.sync_second   <= cfg_data_i;
        CFG_CMD_LIMIT:   cfg_q.command_limit <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  scd_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (fire),
    .data_byte_i   (in_i.data_byte),
    .packet_last_i (in_i.packet_last),
    .cfg_i         (cfg_q),
    .res0_o        (res0),
    .res1_o        (res1),
    .push_cnt_o    (push_cnt)
  );

  scd_outq u_outq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_cnt_i (push_cnt),
    .res0_i     (res0),
    .res1_i     (res1),
    .space_o    (space),
    .valid_o    (out_o.valid),
    .ready_i    (out_o.ready),
    .head_o     (head)
  );

  assign out_o.kind           = head.kind;
  assign out_o.byte_index     = head.byte_index;
  assign out_o.byte_value     = head.byte_value;
  assign out_o.status         = head.status;
  assign out_o.message_done   = head.message_done;
  assign out_o.command        = head.command;
  assign out_o.command_ok     = head.command_ok;
  assign out_o.message_length = head.message_length;
  assign out_o.last           = head.last;

endmodule
